/* src/cpc_pkg.sv */
// Shared types, codes and saturation helper for the cascade PID controller.
// Used by cpc_ctrl, cpc_datapath and the top level; no dependencies.
package cpc_pkg;

  localparam int GAIN_W = 48;
  localparam int DATA_W = 16;

  // Loop selector codes
  localparam logic [1:0] LOOP_STEER = 2'd0;
  localparam logic [1:0] LOOP_RATE  = 2'd1;
  localparam logic [1:0] LOOP_SPEED = 2'd2;

  // Gain term selector codes (also the gain's slot in its register)
  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  // Register indexes on the config port
  localparam logic [1:0] REG_STEER_GAINS = 2'd0;
  localparam logic [1:0] REG_RATE_GAINS  = 2'd1;
  localparam logic [1:0] REG_SPEED_GAINS = 2'd2;

  typedef struct packed {
    logic       load;      // capture an input word
    logic       err;       // form error, update loop state, set up operands
    logic       mul;       // one gain * operand product
    logic [1:0] term;      // which gain / operand for mul
    logic       acc_add;   // add previous product into accumulator
    logic       fin;       // shift, saturate, write loop output
    logic [1:0] loop;      // loop being worked on
    logic       publish;   // move results to the output register
  } cpc_cmd_t;

  typedef struct packed {
    logic out_free;        // output register empty or emptied this cycle
  } cpc_status_t;

  function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
    logic signed [15:0] r;
    if (v > 50'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -50'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

/* src/cascade_pid_controller_core.sv */
// Words are processed one at a time through the single shared 16x32
// multiplier (3 loops x 6 steps, plus capture and output handoff); no new
// word is taken until the previous one is in the output register.
// The next word is taken while a finished result still waits downstream.
// Reset (rst, synchronous, active high) zeroes gains, integrators, error
// history and the drive accumulator, and empties the output register.
// Top level: APB gain registers plus cpc_ctrl and cpc_datapath; uses cpc_pkg.
module cascade_pid_controller_core
  import cpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [4:0]               paddr,
  input  logic [63:0]              pwdata,
  output logic [63:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] steer_setpoint,
  input  logic signed [DATA_W-1:0] steer_measured,
  input  logic signed [DATA_W-1:0] rate_measured,
  input  logic signed [DATA_W-1:0] speed_measured,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] drive_value,
  output logic signed [DATA_W-1:0] rate_setpoint,
  output logic signed [DATA_W-1:0] speed_setpoint
);

  logic [GAIN_W-1:0] steer_gains, rate_gains, speed_gains;
  logic [1:0]        reg_idx;
  logic              wr_en;
  cpc_cmd_t          cmd;
  cpc_status_t       status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_gains <= '0;
      rate_gains  <= '0;
      speed_gains <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_STEER_GAINS: steer_gains <= pwdata[GAIN_W-1:0];
        REG_RATE_GAINS:  rate_gains  <= pwdata[GAIN_W-1:0];
        REG_SPEED_GAINS: speed_gains <= pwdata[GAIN_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STEER_GAINS: prdata = {16'd0, steer_gains};
      REG_RATE_GAINS:  prdata = {16'd0, rate_gains};
      REG_SPEED_GAINS: prdata = {16'd0, speed_gains};
      default:         prdata = 64'd0;
    endcase
  end

  cpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  cpc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .steer_gains    (steer_gains),
    .rate_gains     (rate_gains),
    .speed_gains    (speed_gains),
    .steer_setpoint (steer_setpoint),
    .steer_measured (steer_measured),
    .rate_measured  (rate_measured),
    .speed_measured (speed_measured),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .drive_value    (drive_value),
    .rate_setpoint  (rate_setpoint),
    .speed_setpoint (speed_setpoint)
  );

endmodule

/* src/cpc_ctrl.sv */
// Sequencer for the cascade PID controller: walks three loops through the
// shared multiplier and issues commands to cpc_datapath. Uses cpc_pkg.
module cpc_ctrl
  import cpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  cpc_status_t status,
  output cpc_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ERR  = 3'd1;
  localparam logic [2:0] S_MUL0 = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_PUB  = 3'd7;

  logic [2:0] state, state_next;
  logic [1:0] loop, loop_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    loop_next   = loop;
    cmd         = '0;
    cmd.loop    = loop;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          loop_next  = LOOP_STEER;
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        cmd.err    = 1'b1;
        state_next = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul    = 1'b1;
        cmd.term   = TERM_P;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul     = 1'b1;
        cmd.term    = TERM_I;
        cmd.acc_add = 1'b1;
        state_next  = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul     = 1'b1;
        cmd.term    = TERM_D;
        cmd.acc_add = 1'b1;
        state_next  = S_ADD;
      end
      S_ADD: begin
        cmd.acc_add = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (loop == LOOP_SPEED) begin
          state_next = S_PUB;
        end else begin
          loop_next  = loop + 2'd1;
          state_next = S_ERR;
        end
      end
      S_PUB: begin
        // wait here while a previous word still sits unclaimed
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      loop  <= LOOP_STEER;
    end else begin
      state <= state_next;
      loop  <= loop_next;
    end
  end

endmodule

/* src/cpc_datapath.sv */
// Datapath of the cascade PID controller: loop state, one shared 16x32
// multiplier, accumulator and output register. Driven by cpc_ctrl; uses cpc_pkg.
module cpc_datapath
  import cpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cpc_cmd_t                 cmd,
  output cpc_status_t              status,
  input  logic [GAIN_W-1:0]        steer_gains,
  input  logic [GAIN_W-1:0]        rate_gains,
  input  logic [GAIN_W-1:0]        speed_gains,
  input  logic signed [DATA_W-1:0] steer_setpoint,
  input  logic signed [DATA_W-1:0] steer_measured,
  input  logic signed [DATA_W-1:0] rate_measured,
  input  logic signed [DATA_W-1:0] speed_measured,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] drive_value,
  output logic signed [DATA_W-1:0] rate_setpoint,
  output logic signed [DATA_W-1:0] speed_setpoint
);

  // captured inputs
  logic signed [15:0] in_st, in_sm, in_rm, in_spm;
  // loop outputs of the current tick
  logic signed [15:0] rate_sp, speed_sp;
  // loop state
  logic signed [31:0] steer_sum, rate_sum;
  logic signed [15:0] steer_last, rate_last, spd_e1, spd_e2, spd_acc;
  // multiplier operands, product and accumulator
  logic signed [31:0] op0, op1, op2;
  logic signed [47:0] prod;
  logic signed [49:0] acc;

  // error stage
  logic signed [15:0] tgt, meas, e, last_sel;
  logic signed [16:0] diff;
  logic signed [31:0] sum_old, sum_new;
  logic signed [32:0] sum33;
  logic signed [16:0] pos_d;
  logic signed [16:0] inc_p;
  logic signed [18:0] inc_d;

  // multiply stage
  logic [GAIN_W-1:0]  gains_sel;
  logic signed [15:0] gain;
  logic signed [31:0] op_sel;

  // finish stage
  logic signed [41:0] q;
  logic signed [42:0] acc43;

  always_comb begin
    case (cmd.loop)
      LOOP_STEER: begin
        tgt = in_st;   meas = in_sm;  sum_old = steer_sum; last_sel = steer_last;
      end
      LOOP_RATE: begin
        tgt = rate_sp; meas = in_rm;  sum_old = rate_sum;  last_sel = rate_last;
      end
      default: begin
        tgt = speed_sp; meas = in_spm; sum_old = 32'sd0;   last_sel = spd_e1;
      end
    endcase

    diff = {tgt[15], tgt} - {meas[15], meas};
    if (diff[16] != diff[15]) begin
      e = diff[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      e = diff[15:0];
    end

    sum33 = {sum_old[31], sum_old} + {{17{e[15]}}, e};
    if (sum33[32] != sum33[31]) begin
      sum_new = sum33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sum_new = sum33[31:0];
    end

    pos_d = {e[15], e} - {last_sel[15], last_sel};
    inc_p = {e[15], e} - {spd_e1[15], spd_e1};
    inc_d = {{3{e[15]}}, e} - {{2{spd_e1[15]}}, spd_e1, 1'b0} + {{3{spd_e2[15]}}, spd_e2};

    case (cmd.loop)
      LOOP_STEER: gains_sel = steer_gains;
      LOOP_RATE:  gains_sel = rate_gains;
      default:    gains_sel = speed_gains;
    endcase
    case (cmd.term)
      TERM_P: begin
        gain = gains_sel[15:0];  op_sel = op0;
      end
      TERM_I: begin
        gain = gains_sel[31:16]; op_sel = op1;
      end
      TERM_D: begin
        gain = gains_sel[47:32]; op_sel = op2;
      end
      default: begin
        gain = 16'sd0;           op_sel = 32'sd0;
      end
    endcase

    // floor divide by 256
    q     = acc[49:8];
    acc43 = {q[41], q} + {{27{spd_acc[15]}}, spd_acc};
  end

  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_st  <= steer_setpoint;
      in_sm  <= steer_measured;
      in_rm  <= rate_measured;
      in_spm <= speed_measured;
    end
    if (cmd.err) begin
      acc <= '0;
      if (cmd.loop == LOOP_SPEED) begin
        op0 <= {{15{inc_p[16]}}, inc_p};
        op1 <= {{16{e[15]}}, e};
        op2 <= {{13{inc_d[18]}}, inc_d};
      end else begin
        op0 <= {{16{e[15]}}, e};
        op1 <= sum_new;
        op2 <= {{15{pos_d[16]}}, pos_d};
      end
    end else if (cmd.acc_add) begin
      acc <= acc + {{2{prod[47]}}, prod};
    end
    if (cmd.mul) begin
      prod <= gain * op_sel;
    end
    if (cmd.fin) begin
      case (cmd.loop)
        LOOP_STEER: rate_sp  <= sat16({{8{q[41]}}, q});
        LOOP_RATE:  speed_sp <= sat16({{8{q[41]}}, q});
        default:    ;
      endcase
    end
    if (cmd.publish) begin
      rate_setpoint  <= rate_sp;
      speed_setpoint <= speed_sp;
      drive_value    <= spd_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_sum  <= '0;
      steer_last <= '0;
      rate_sum   <= '0;
      rate_last  <= '0;
      spd_e1     <= '0;
      spd_e2     <= '0;
      spd_acc    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.err) begin
        case (cmd.loop)
          LOOP_STEER: begin
            steer_sum  <= sum_new;
            steer_last <= e;
          end
          LOOP_RATE: begin
            rate_sum  <= sum_new;
            rate_last <= e;
          end
          default: begin
            spd_e2 <= spd_e1;
            spd_e1 <= e;
          end
        endcase
      end
      if (cmd.fin && cmd.loop == LOOP_SPEED) begin
        spd_acc <= sat16({{7{acc43[42]}}, acc43});
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* sim/tb_cascade_pid_controller_core.sv */
// Testbench for cascade_pid_controller_core: drives control ticks and APB gain writes,
// predicts the three cascaded loops in fixed point and checks every output word.
// Depends on cpc_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_cascade_pid_controller_core
  import cpc_pkg::*;
();

  localparam int STALL_LIMIT = 3000;   // cycles with no word moving on either side
  localparam int HOLD_CYCLES = 300;
  localparam int INTEGRAL_TICKS = 24;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [15:0] drive;
    logic signed [15:0] rate_sp;
    logic signed [15:0] speed_sp;
  } tick_outputs_t;

  class cascade_checker;
    logic [47:0] steer_gains, rate_gains, speed_gains;
    int steer_sum, steer_last, rate_sum, rate_last;
    int speed_e1, speed_e2, drive_acc;
    tick_outputs_t due_outputs[$];
    int checked;
    int errors;

    function new();
      steer_gains = '0;
      rate_gains = '0;
      speed_gains = '0;
      steer_sum = 0;
      steer_last = 0;
      rate_sum = 0;
      rate_last = 0;
      speed_e1 = 0;
      speed_e2 = 0;
      drive_acc = 0;
      checked = 0;
      errors = 0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function longint gain(logic [47:0] g, int k);
      logic signed [15:0] h;
      h = g[16*k +: 16];
      return longint'(h);
    endfunction

    function void set_gains(logic [1:0] idx, logic [63:0] value);
      case (idx)
        REG_STEER_GAINS: steer_gains = value[47:0];
        REG_RATE_GAINS:  rate_gains = value[47:0];
        REG_SPEED_GAINS: speed_gains = value[47:0];
        default: ;
      endcase
    endfunction

    function int positional(logic [47:0] g, int target, int measured,
                            inout int sum, inout int last);
      int e;
      longint p;
      e = int'(clamp(longint'(target) - measured, -32768, 32767));
      sum = int'(clamp(longint'(sum) + e, -64'sd2147483648, 64'sd2147483647));
      p = gain(g, 0) * e + gain(g, 1) * sum + gain(g, 2) * (longint'(e) - last);
      last = e;
      return int'(clamp(p >>> 8, -32768, 32767));
    endfunction

    function int incremental(logic [47:0] g, int target, int measured);
      int e;
      longint p;
      e = int'(clamp(longint'(target) - measured, -32768, 32767));
      p = gain(g, 0) * (longint'(e) - speed_e1)
        + gain(g, 1) * e
        + gain(g, 2) * (longint'(e) - 2 * longint'(speed_e1) + speed_e2);
      drive_acc = int'(clamp(longint'(drive_acc) + (p >>> 8), -32768, 32767));
      speed_e2 = speed_e1;
      speed_e1 = e;
      return drive_acc;
    endfunction

    function void predict_tick(logic signed [15:0] st, logic signed [15:0] sm,
                               logic signed [15:0] rm, logic signed [15:0] sp);
      tick_outputs_t o;
      int rate_t, speed_t;
      rate_t = positional(steer_gains, st, sm, steer_sum, steer_last);
      speed_t = positional(rate_gains, rate_t, rm, rate_sum, rate_last);
      o.drive = 16'(incremental(speed_gains, speed_t, sp));
      o.rate_sp = 16'(rate_t);
      o.speed_sp = 16'(speed_t);
      due_outputs.push_back(o);
    endfunction

    function int pending();
      return due_outputs.size();
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(logic signed [15:0] dv, logic signed [15:0] rs,
                      logic signed [15:0] ss);
      tick_outputs_t w;
      if (due_outputs.size() == 0) begin
        report($sformatf("output word %0d arrived with nothing expected", checked));
      end else begin
        w = due_outputs.pop_front();
        if (dv !== w.drive)
          report($sformatf("word %0d drive_value got %0d want %0d", checked, dv, w.drive));
        if (rs !== w.rate_sp)
          report($sformatf("word %0d rate_setpoint got %0d want %0d", checked, rs,
                           w.rate_sp));
        if (ss !== w.speed_sp)
          report($sformatf("word %0d speed_setpoint got %0d want %0d", checked, ss,
                           w.speed_sp));
      end
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] steer_setpoint = '0;
  logic signed [15:0] steer_measured = '0;
  logic signed [15:0] rate_measured = '0;
  logic signed [15:0] speed_measured = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [15:0] drive_value;
  logic signed [15:0] rate_setpoint;
  logic signed [15:0] speed_setpoint;

  cascade_checker sb;
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;
  int hold_req = 0;
  int idle_cycles = 0;

  cascade_pid_controller_core uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .steer_setpoint(steer_setpoint), .steer_measured(steer_measured),
    .rate_measured(rate_measured), .speed_measured(speed_measured),
    .out_valid(out_valid), .out_stall(out_stall),
    .drive_value(drive_value), .rate_setpoint(rate_setpoint),
    .speed_setpoint(speed_setpoint)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // output checking and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && !out_stall)
        sb.check_result(drive_value, rate_setpoint, speed_setpoint);
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver: random stall per word, or a long hold-off on request
  initial begin : receiver
    int n;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end else if (recv_quiet) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 7);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(0, 1023)) - 16'd512;
    if (r < 85) return 16'($urandom);
    case ($urandom_range(0, 3))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 16'($urandom_range(0, 1023)) - 16'd512;
    if (r < 80) return 16'($urandom);
    case ($urandom_range(0, 4))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'h0001;
      default: return 16'hffff;
    endcase
  endfunction

  task automatic send_tick(input logic [15:0] st, input logic [15:0] sm,
                           input logic [15:0] rm, input logic [15:0] sp);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    steer_setpoint <= st;
    steer_measured <= sm;
    rate_measured <= rm;
    speed_measured <= sp;
    do @(posedge clk); while (in_stall);
    sb.predict_tick(st, sm, rm, sp);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_gains(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // upper 16 bits carry junk; the unused slot gets a write that must not stick
  task automatic load_gains(input logic [47:0] s, input logic [47:0] r,
                            input logic [47:0] v);
    write_reg(REG_UNUSED, {32'($urandom), 32'($urandom)});
    write_reg(REG_STEER_GAINS, {16'($urandom), s});
    write_reg(REG_RATE_GAINS, {16'($urandom), r});
    write_reg(REG_SPEED_GAINS, {16'($urandom), v});
  endtask

  initial begin : main
    int i, p, phase_len;
    logic [47:0] gs, gr, gv;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // gains are zero out of reset
    send_tick(16'h7fff, 16'h8000, 16'h1234, 16'hedcb);
    send_tick(16'h0100, 16'h0000, 16'h8000, 16'h7fff);
    send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    drain_results();

    // directed: moderate gains, field extremes, error saturation both ways
    load_gains({16'h0040, 16'h0008, 16'h0100}, {16'h0020, 16'h0004, 16'h0180},
               {16'h0010, 16'h0020, 16'h0200});
    send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tick(16'h7fff, 16'h8000, 16'h0000, 16'h0000);
    send_tick(16'h8000, 16'h7fff, 16'h0000, 16'h0000);
    send_tick(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_tick(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_tick(16'hffff, 16'h0000, 16'hffff, 16'h0000);
    send_tick(16'h0000, 16'hffff, 16'h0000, 16'hffff);
    send_tick(16'h0100, 16'hff00, 16'h8000, 16'h7fff);
    send_tick(16'hff00, 16'h0100, 16'h7fff, 16'h8000);
    send_tick(16'h1234, 16'hfedc, 16'h0a0a, 16'hf5f5);
    send_tick(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_tick(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    drain_results();

    // extreme gains: every loop output and the accumulator saturate
    load_gains({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}});
    send_tick(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_tick(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_tick(16'h0010, 16'h0000, 16'h0020, 16'h0030);
    send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    drain_results();
    load_gains({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    send_tick(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_tick(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_tick(16'h0010, 16'h0000, 16'h0020, 16'h0030);
    send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    drain_results();

    // integral windup: full-scale errors pile up in both error sums, then reverse;
    // ki of -1 and +1 LSB makes the sums show up in the outputs, scaled down by 256
    send_quiet = 1'b1;
    recv_quiet = 1'b1;
    load_gains({16'h0000, 16'hffff, 16'h0000}, {16'h0000, 16'h0001, 16'h0000},
               {16'h0000, 16'h0100, 16'h0000});
    for (i = 0; i < INTEGRAL_TICKS; i++)
      send_tick(16'h7fff, 16'h8000, 16'h7fff, pick_sample());
    for (i = 0; i < 12; i++)
      send_tick(16'h8000, 16'h7fff, 16'h8000, pick_sample());
    drain_results();

    // random phases with fresh gains each time
    for (p = 0; p < 6; p++) begin
      for (i = 0; i < 3; i++) begin
        gs[16*i +: 16] = (p == 0) ? 16'($urandom_range(0, 511)) - 16'd256 : pick_gain();
        gr[16*i +: 16] = (p == 0) ? 16'($urandom_range(0, 511)) - 16'd256 : pick_gain();
        gv[16*i +: 16] = (p == 0) ? 16'($urandom_range(0, 511)) - 16'd256 : pick_gain();
      end
      load_gains(gs, gr, gv);
      send_quiet = (p == 1 || p == 2);
      recv_quiet = (p == 1);
      if (p == 2) hold_req = HOLD_CYCLES;   // receiver backs up, input side must stall
      phase_len = 170 + $urandom_range(0, 20);
      for (i = 0; i < phase_len; i++) begin
        send_tick(pick_sample(), pick_sample(), pick_sample(), pick_sample());
        if ($urandom_range(0, 59) == 0) drain_results();
      end
      drain_results();
    end

    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
